// ----- src/ir_pulse_distance_sender_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef IR_PULSE_DISTANCE_SENDER_MACROS_SVH
`define IR_PULSE_DISTANCE_SENDER_MACROS_SVH

// Same-cycle implication, off during reset.
`define IRPDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpds check failed");

// Next-cycle implication, off during reset.
`define IRPDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irpds check failed");

`endif

// ----- src/irpds_pkg.sv -----
package irpds_pkg;

  localparam int DUR_W       = 16;
  localparam int CH_W        = 2;
  localparam int DATA_W      = 8;
  localparam int REG_IDX_W   = 3;
  localparam int BITS_PER_FRAME_DEF = 8;

  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ZERO_SPACE = 3'd3,
    REG_ONE_SPACE  = 3'd4,
    REG_TRL_MARK   = 3'd5,
    REG_TRL_SPACE  = 3'd6
  } reg_idx_t;

  localparam logic [DUR_W-1:0] HDR_MARK_RST   = 16'd9000;
  localparam logic [DUR_W-1:0] HDR_SPACE_RST  = 16'd4500;
  localparam logic [DUR_W-1:0] BIT_MARK_RST   = 16'd560;
  localparam logic [DUR_W-1:0] ZERO_SPACE_RST = 16'd560;
  localparam logic [DUR_W-1:0] ONE_SPACE_RST  = 16'd1690;
  localparam logic [DUR_W-1:0] TRL_MARK_RST   = 16'd9000;
  localparam logic [DUR_W-1:0] TRL_SPACE_RST  = 16'd2250;

  typedef struct packed {
    logic [DUR_W-1:0] hdr_mark;
    logic [DUR_W-1:0] hdr_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] zero_space;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] trl_mark;
    logic [DUR_W-1:0] trl_space;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_MARK,
    ST_HDR_SPACE,
    ST_BIT_MARK,
    ST_BIT_SPACE,
    ST_TRL_MARK,
    ST_TRL_SPACE
  } seq_state_t;

endpackage

// ----- src/irpds_req_if.sv -----
interface irpds_req_if
  import irpds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output channel, output data_byte, input ready);
  modport sink   (input valid, input channel, input data_byte, output ready);
endinterface

// ----- src/irpds_seg_if.sv -----
interface irpds_seg_if
  import irpds_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  emitter;
  logic             level;
  logic [DUR_W-1:0] duration_us;
  logic             last;

  modport source (output valid, output emitter, output level, output duration_us,
                  output last, input ready);
  modport sink   (input valid, input emitter, input level, input duration_us,
                  input last, output ready);
endinterface

// ----- src/irpds_cfg_regs.sv -----
module irpds_cfg_regs
  import irpds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr_mark   <= HDR_MARK_RST;
      cfg.hdr_space  <= HDR_SPACE_RST;
      cfg.bit_mark   <= BIT_MARK_RST;
      cfg.zero_space <= ZERO_SPACE_RST;
      cfg.one_space  <= ONE_SPACE_RST;
      cfg.trl_mark   <= TRL_MARK_RST;
      cfg.trl_space  <= TRL_SPACE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HDR_MARK:   cfg.hdr_mark   <= cfg_wdata;
        REG_HDR_SPACE:  cfg.hdr_space  <= cfg_wdata;
        REG_BIT_MARK:   cfg.bit_mark   <= cfg_wdata;
        REG_ZERO_SPACE: cfg.zero_space <= cfg_wdata;
        REG_ONE_SPACE:  cfg.one_space  <= cfg_wdata;
        REG_TRL_MARK:   cfg.trl_mark   <= cfg_wdata;
        REG_TRL_SPACE:  cfg.trl_space  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/irpds_frame_seq.sv -----
module irpds_frame_seq
  import irpds_pkg::*;
#(
  parameter int BITS_PER_FRAME = BITS_PER_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  irpds_req_if.sink   req,
  irpds_seg_if.source seg
);

  localparam int CNT_W = $clog2(BITS_PER_FRAME + 1);

  seq_state_t        state, state_next;
  logic [CH_W-1:0]   ch;
  logic [DATA_W-1:0] data;   // MSB is the bit being sent
  logic [CNT_W-1:0]  bits_left;
  logic              seg_valid;
  logic              adv;
  logic              seg_load;
  logic              lvl_next;
  logic [DUR_W-1:0]  dur_next;
  logic              last_next;
  logic              start;

  assign adv   = !seg_valid || seg.ready;
  assign start = req.valid && req.ready && (req.channel != CH_NONE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (start) state_next = ST_HDR_MARK;
      ST_HDR_MARK:  if (adv) state_next = ST_HDR_SPACE;
      ST_HDR_SPACE: if (adv) state_next = ST_BIT_MARK;
      ST_BIT_MARK:  if (adv) state_next = ST_BIT_SPACE;
      ST_BIT_SPACE: if (adv) state_next = (bits_left == CNT_W'(1)) ? ST_TRL_MARK : ST_BIT_MARK;
      ST_TRL_MARK:  if (adv) state_next = ST_TRL_SPACE;
      ST_TRL_SPACE: if (adv) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    seg_load  = 1'b0;
    lvl_next  = 1'b0;
    dur_next  = cfg.trl_space;
    last_next = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_HDR_MARK: begin
        seg_load = adv;
        lvl_next = 1'b1;
        dur_next = cfg.hdr_mark;
      end
      ST_HDR_SPACE: begin
        seg_load = adv;
        dur_next = cfg.hdr_space;
      end
      ST_BIT_MARK: begin
        seg_load = adv;
        lvl_next = 1'b1;
        dur_next = cfg.bit_mark;
      end
      ST_BIT_SPACE: begin
        seg_load = adv;
        dur_next = data[DATA_W-1] ? cfg.one_space : cfg.zero_space;
      end
      ST_TRL_MARK: begin
        seg_load = adv;
        lvl_next = 1'b1;
        dur_next = cfg.trl_mark;
      end
      ST_TRL_SPACE: begin
        seg_load  = adv;
        last_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seg_load) begin
        seg_valid <= 1'b1;
      end else if (seg.ready) begin
        seg_valid <= 1'b0;
      end
    end
  end

  // One data bit leaves the shift register per bit space; zeros fill behind.
  always_ff @(posedge clk) begin
    if (start) begin
      ch        <= req.channel;
      data      <= req.data_byte;
      bits_left <= CNT_W'(BITS_PER_FRAME);
    end else if (seg_load && state == ST_BIT_SPACE) begin
      data      <= {data[DATA_W-2:0], 1'b0};
      bits_left <= bits_left - CNT_W'(1);
    end
    if (seg_load) begin
      seg.emitter     <= ch;
      seg.level       <= lvl_next;
      seg.duration_us <= dur_next;
      seg.last        <= last_next;
    end
  end

  assign seg.valid = seg_valid;

endmodule

// ----- src/ir_pulse_distance_sender.sv -----
// Channel  Dir  Transfer carries
// req      in   channel, data_byte (one frame request)
// seg      out  emitter, level, duration_us, last (one timed segment)
// cfg      in   cfg_we, cfg_index, cfg_wdata (timing register write)
//
// A request is accepted while the sequencer is idle; the frame sequencer then
// emits one segment per cycle while seg is ready.
// Channel 3 is accepted while idle and yields no segment.
// Stalls on seg hold the sequencer; req is ready only between frames.
// Reset (rst, synchronous) loads the timing registers with their defaults.
module ir_pulse_distance_sender
  import irpds_pkg::*;
#(
  parameter int BITS_PER_FRAME = BITS_PER_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  irpds_req_if.sink            req,
  irpds_seg_if.source          seg,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_wdata
);

  cfg_t cfg;

  irpds_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irpds_frame_seq #(
    .BITS_PER_FRAME (BITS_PER_FRAME)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .seg (seg)
  );

endmodule

// ----- src/irpds_checker.sv -----
`include "ir_pulse_distance_sender_macros.svh"

module irpds_checker
  import irpds_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic [CH_W-1:0] req_channel,
  input logic            seg_valid,
  input logic            seg_ready,
  input logic            seg_last
);

  `IRPDS_ASSERT_NEXT(a_seg_hold, clk, rst, seg_valid && !seg_ready, seg_valid)
  `IRPDS_ASSERT_NOW(a_idle_only_trailer, clk, rst, req_ready && seg_valid, seg_last)
  `IRPDS_ASSERT_NEXT(a_gap_after_last, clk, rst, seg_valid && seg_ready && seg_last, !(seg_valid && seg_last))
  `IRPDS_ASSERT_NEXT(a_busy_after_start, clk, rst, req_valid && req_ready && (req_channel != CH_NONE), !req_ready)

endmodule

bind ir_pulse_distance_sender irpds_checker u_irpds_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_channel (req.channel),
  .seg_valid   (seg.valid),
  .seg_ready   (seg.ready),
  .seg_last    (seg.last)
);

// ----- bench/ir_pulse_distance_sender_test.sv -----
module ir_pulse_distance_sender_test;
  import irpds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBITS = BITS_PER_FRAME_DEF;
  localparam int SETTLE = 2 * NBITS + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_LEN = 25;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [CH_W-1:0]  emitter;
    logic             level;
    logic [DUR_W-1:0] duration_us;
    logic             last;
  } seg_t;

  typedef enum {ROW_REQ, ROW_CFG, ROW_CFG_ALL} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] data;
    logic [REG_IDX_W-1:0] idx;
    logic [DUR_W-1:0]  val;
    bit                typed;
    logic [DUR_W-1:0]  first_dur;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0] cfg_wdata;

  irpds_req_if req_ch ();
  irpds_seg_if seg_ch ();

  ir_pulse_distance_sender u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .seg       (seg_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t timing;
  seg_t segs_due[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 14;
  int   recv_idle_pct = 51;
  bit   typed_pending = 0;
  logic [DUR_W-1:0] typed_first = '0;

  // Directed plan; typed rows carry the expected header mark as a literal in the plan.
  row_t plan [PLAN_LEN] = '{
    '{ROW_REQ,     2'd0,    8'h00, REG_HDR_MARK,   16'h0000, 1'b1, 16'd9000},
    '{ROW_REQ,     2'd1,    8'hFF, REG_HDR_MARK,   16'h0000, 1'b1, 16'd9000},
    '{ROW_REQ,     CH_NONE, 8'h5A, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd2,    8'hA5, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REQ,     CH_NONE, 8'hFF, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd0,    8'h80, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG_ALL, 2'd0,    8'h00, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_UNUSED,     16'h1234, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd1,    8'hC3, REG_HDR_MARK,   16'h0000, 1'b1, 16'h0000},
    '{ROW_REQ,     2'd2,    8'h3C, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG_ALL, 2'd0,    8'h00, REG_HDR_MARK,   16'hFFFF, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd0,    8'hFF, REG_HDR_MARK,   16'h0000, 1'b1, 16'hFFFF},
    '{ROW_REQ,     2'd2,    8'h00, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REQ,     CH_NONE, 8'h00, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_HDR_MARK,   16'h0001, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_HDR_SPACE,  16'h8000, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_BIT_MARK,   16'h7FFF, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_ZERO_SPACE, 16'h5555, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_ONE_SPACE,  16'hAAAA, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_TRL_MARK,   16'hFFFE, 1'b0, 16'h0000},
    '{ROW_CFG,     2'd0,    8'h00, REG_TRL_SPACE,  16'h00FF, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd1,    8'h55, REG_HDR_MARK,   16'h0000, 1'b1, 16'h0001},
    '{ROW_REQ,     2'd2,    8'hAA, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd0,    8'h01, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000},
    '{ROW_REQ,     2'd1,    8'h80, REG_HDR_MARK,   16'h0000, 1'b0, 16'h0000}
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ir_pulse_distance_sender_test: FAIL");
      $finish;
    end
  end

  always @(negedge clk) seg_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic void predict_frame(logic [CH_W-1:0] ch, logic [DATA_W-1:0] d);
    bit one;
    if (ch == CH_NONE) return;
    segs_due.push_back('{ch, 1'b1, timing.hdr_mark, 1'b0});
    segs_due.push_back('{ch, 1'b0, timing.hdr_space, 1'b0});
    for (int i = 0; i < NBITS; i++) begin
      one = (i < DATA_W) && d[DATA_W-1-i];
      segs_due.push_back('{ch, 1'b1, timing.bit_mark, 1'b0});
      segs_due.push_back('{ch, 1'b0, one ? timing.one_space : timing.zero_space, 1'b0});
    end
    segs_due.push_back('{ch, 1'b1, timing.trl_mark, 1'b0});
    segs_due.push_back('{ch, 1'b0, timing.trl_space, 1'b1});
  endfunction

  always @(posedge clk) begin : monitor
    int   n0;
    seg_t want;
    if (rst) begin
      timing = '{HDR_MARK_RST, HDR_SPACE_RST, BIT_MARK_RST, ZERO_SPACE_RST,
                 ONE_SPACE_RST, TRL_MARK_RST, TRL_SPACE_RST};
      segs_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HDR_MARK:   timing.hdr_mark = cfg_wdata;
          REG_HDR_SPACE:  timing.hdr_space = cfg_wdata;
          REG_BIT_MARK:   timing.bit_mark = cfg_wdata;
          REG_ZERO_SPACE: timing.zero_space = cfg_wdata;
          REG_ONE_SPACE:  timing.one_space = cfg_wdata;
          REG_TRL_MARK:   timing.trl_mark = cfg_wdata;
          REG_TRL_SPACE:  timing.trl_space = cfg_wdata;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        n0 = segs_due.size();
        predict_frame(req_ch.channel, req_ch.data_byte);
        if (typed_pending && segs_due.size() > n0) segs_due[n0].duration_us = typed_first;
        typed_pending = 0;
      end
      if (seg_ch.valid && seg_ch.ready) begin
        if (segs_due.size() == 0) begin
          $error("segment transfer with nothing pending: emitter %0d level %0d dur %0d",
                 seg_ch.emitter, seg_ch.level, seg_ch.duration_us);
          errors++;
        end else begin
          want = segs_due.pop_front();
          if (want.emitter !== seg_ch.emitter) begin
            $error("emitter: expected %0d, got %0d", want.emitter, seg_ch.emitter);
            errors++;
          end
          if (want.level !== seg_ch.level) begin
            $error("level: expected %0d, got %0d", want.level, seg_ch.level);
            errors++;
          end
          if (want.duration_us !== seg_ch.duration_us) begin
            $error("duration_us: expected %0d, got %0d", want.duration_us,
                   seg_ch.duration_us);
            errors++;
          end
          if (want.last !== seg_ch.last) begin
            $error("last: expected %0d, got %0d", want.last, seg_ch.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_req(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] d,
                          input bit typed, input logic [DUR_W-1:0] first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_pending = typed;
    typed_first = first;
    req_ch.valid <= 1'b1;
    req_ch.channel <= ch;
    req_ch.data_byte <= d;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_frames_done();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int items [3];
    bit sent;
    logic [DUR_W-1:0] v;
    logic [CH_W-1:0] ch;
    items = '{90, 90, 80};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.channel = '0;
    req_ch.data_byte = '0;
    seg_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sent = 0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REQ) begin
        send_req(plan[r].ch, plan[r].data, plan[r].typed, plan[r].first_dur);
        sent = 1;
      end else begin
        if (sent) wait_frames_done();
        sent = 0;
        if (plan[r].kind == ROW_CFG) cfg_write(plan[r].idx, plan[r].val);
        else
          for (int i = 0; i <= REG_TRL_SPACE; i++) cfg_write(REG_IDX_W'(i), plan[r].val);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 14 : 0;
      wait_frames_done();
      for (int i = 0; i <= REG_TRL_SPACE; i++) begin
        case ($urandom_range(5))
          0: v = '0;
          1: v = '1;
          default: v = DUR_W'($urandom_range(65535));
        endcase
        cfg_write(REG_IDX_W'(i), v);
      end
      if (ph == 1) cfg_write(REG_UNUSED, DUR_W'($urandom_range(65535)));
      for (int n = 0; n < items[ph]; n++) begin
        // hold off until the block has drained completely
        if (ph == 0 && n == 40) wait_frames_done();
        ch = ($urandom_range(9) == 0) ? CH_NONE : CH_W'($urandom_range(2));
        send_req(ch, DATA_W'($urandom_range(255)), 1'b0, '0);
      end
    end

    wait_frames_done();
    if (errors == 0) begin
      $display("ir_pulse_distance_sender_test: PASS");
    end else begin
      $display("ir_pulse_distance_sender_test: FAIL");
    end
    $finish;
  end

endmodule
